[rtl/wsd_pkg.sv]
// Shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HEAD = 3'd0,
    PH_LEN  = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_BODY = 3'd4,
    PH_HALT = 3'd5
  } wsd_phase_t;

  // Frame opcodes
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'ha;

  // Header byte fields
  localparam logic [7:0] HDR_TOP_BIT   = 8'h80;
  localparam logic [7:0] HDR_OP_MASK   = 8'h0f;
  localparam logic [6:0] LEN_CODE_16   = 7'd126;
  localparam logic [3:0] EXT_BYTES_16  = 4'd2;
  localparam logic [3:0] EXT_BYTES_64  = 4'd8;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_EVENT   = 2'd2;

  // Close and error reasons
  localparam logic [2:0] RSN_NONE     = 3'd0;
  localparam logic [2:0] RSN_BAD_OP   = 3'd1;
  localparam logic [2:0] RSN_UNMASKED = 3'd2;
  localparam logic [2:0] RSN_STREAM   = 3'd3;
  localparam logic [2:0] RSN_CLOSE    = 3'd4;

  // Bad frame codes held during a frame
  localparam logic [1:0] BAD_NONE     = 2'd0;
  localparam logic [1:0] BAD_OP       = 2'd1;
  localparam logic [1:0] BAD_UNMASKED = 2'd2;

  // One result beat
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [3:0]  opcode;
    logic        fin;
    logic        last;
    logic [2:0]  reason;
    logic [15:0] code;
  } wsd_result_t;

endpackage

[rtl/websocket_frame_deframer_core.sv]
// Top level of the WebSocket frame deframer: parser plus result register.
// Each accepted beat carries one stream byte (or an end-of-stream mark) and is
// parsed in the cycle it is accepted; any result it causes is registered and
// shown on the output in the next cycle, so the block sustains one byte per
// clock unless stalled. The only back-pressure comes from the single result
// register: in_stall is high while that register holds a beat that the output
// side is stalling. After a close, error or stream-end event the block keeps
// taking input beats but gives no results until reset (no clearing pass).
module websocket_frame_deframer_core #(
  parameter int LENGTH_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic        cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        stream_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [7:0]  payload_byte,
  output logic [3:0]  frame_opcode,
  output logic        final_fragment,
  output logic        last_of_frame,
  output logic [2:0]  close_reason,
  output logic [15:0] peer_close_code
);
  import wsd_pkg::*;

  logic        accept;
  logic        res_valid;
  wsd_result_t res, held;

  // Input beat is taken unless the result register is full and stalled
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  wsd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .accept         (accept),
    .data_byte      (data_byte),
    .stream_end     (stream_end),
    .res_valid      (res_valid),
    .res            (res)
  );

  wsd_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && res_valid),
    .load_data  (res),
    .full       (out_valid),
    .take_stall (out_stall),
    .data       (held)
  );

  assign result_kind     = held.kind;
  assign payload_byte    = held.data;
  assign frame_opcode    = held.opcode;
  assign final_fragment  = held.fin;
  assign last_of_frame   = held.last;
  assign close_reason    = held.reason;
  assign peer_close_code = held.code;

  // Event and empty-frame beats always close out a frame
  a_event_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind != KIND_PAYLOAD) |-> last_of_frame)
    else $error("event beat without last_of_frame");

  // Payload data only appears on payload beats
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind != KIND_PAYLOAD) |-> (payload_byte == 8'd0))
    else $error("non-payload beat carries data");

  // A reason is given exactly on event beats: close, error or end of stream
  a_reason_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((close_reason != RSN_NONE) == (result_kind == KIND_EVENT)))
    else $error("close_reason does not match result_kind");

  // A status code only comes with a received close
  a_code_close: assert property (@(posedge clk) disable iff (rst)
    out_valid && (peer_close_code != 16'd0) |-> (close_reason == RSN_CLOSE))
    else $error("close code outside a close event");

endmodule

[rtl/wsd_parser.sv]
// Frame header parser, unmasking and event generation, one byte per beat.
module wsd_parser #(
  parameter int LENGTH_BITS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic               cfg_write_data,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               stream_end,
  output logic               res_valid,
  output wsd_pkg::wsd_result_t res
);
  import wsd_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_ZERO = '0;
  localparam logic [LENGTH_BITS-1:0] LEN_ONE  = {{(LENGTH_BITS-1){1'b0}}, 1'b1};

  wsd_phase_t             phase, phase_next;
  logic                   server_mode;
  logic                   fin_flag, fin_flag_next;
  logic [3:0]             opcode_reg, opcode_reg_next;
  logic                   mask_present, mask_present_next;
  logic [LENGTH_BITS-1:0] bytes_left, bytes_left_next;
  logic [3:0]             ext_len_count, ext_len_count_next;
  logic [31:0]            mask_key, mask_key_next;
  logic [1:0]             key_index, key_index_next;
  logic [15:0]            close_code_acc, close_code_acc_next;
  logic [1:0]             close_byte_count, close_byte_count_next;
  logic [1:0]             bad_reason, bad_reason_next;

  logic        length_known, body_start, frame_end, op_known;
  logic [1:0]  key_sel;
  logic [7:0]  key_byte, body_byte;
  logic        body_last;

  // Key byte for the current payload position, first key byte on top
  assign key_sel  = 2'd3 - key_index;
  assign key_byte = mask_key[{key_sel, 3'b000} +: 8];
  assign body_byte = mask_present ? (data_byte ^ key_byte) : data_byte;
  assign body_last = (bytes_left == LEN_ONE);

  assign op_known = (opcode_reg == OP_TEXT) || (opcode_reg == OP_BIN) ||
                    (opcode_reg == OP_CLOSE) || (opcode_reg == OP_PING) ||
                    (opcode_reg == OP_PONG);

  // Next state and result for the byte at the input
  always_comb begin
    phase_next            = phase;
    fin_flag_next         = fin_flag;
    opcode_reg_next       = opcode_reg;
    mask_present_next     = mask_present;
    bytes_left_next       = bytes_left;
    ext_len_count_next    = ext_len_count;
    mask_key_next         = mask_key;
    key_index_next        = key_index;
    close_code_acc_next   = close_code_acc;
    close_byte_count_next = close_byte_count;
    bad_reason_next       = bad_reason;
    length_known          = 1'b0;
    body_start            = 1'b0;
    frame_end             = 1'b0;
    res_valid             = 1'b0;
    res                   = '0;

    if (phase != PH_HALT) begin
      if (stream_end) begin
        phase_next = PH_HALT;
        res_valid  = 1'b1;
        res.kind   = KIND_EVENT;
        res.last   = 1'b1;
        res.reason = RSN_STREAM;
      end else begin
        unique case (phase)
          PH_HEAD: begin
            fin_flag_next         = |(data_byte & HDR_TOP_BIT);
            opcode_reg_next       = 4'(data_byte & HDR_OP_MASK);
            close_code_acc_next   = '0;
            close_byte_count_next = '0;
            phase_next            = PH_LEN;
          end
          PH_LEN: begin
            mask_present_next = data_byte[7];
            priority if (server_mode && !data_byte[7]) begin
              bad_reason_next = BAD_UNMASKED;
            end else if (op_known) begin
              bad_reason_next = BAD_NONE;
            end else begin
              bad_reason_next = BAD_OP;
            end
            if (data_byte[6:0] < LEN_CODE_16) begin
              bytes_left_next = LENGTH_BITS'(data_byte[6:0]);
              length_known    = 1'b1;
            end else begin
              bytes_left_next    = LEN_ZERO;
              ext_len_count_next = (data_byte[6:0] == LEN_CODE_16) ? EXT_BYTES_16
                                                                   : EXT_BYTES_64;
              phase_next         = PH_EXT;
            end
          end
          PH_EXT: begin
            bytes_left_next    = LENGTH_BITS'({bytes_left, data_byte});
            ext_len_count_next = ext_len_count - 4'd1;
            if (ext_len_count_next == 4'd0) begin
              length_known = 1'b1;
            end
          end
          PH_KEY: begin
            mask_key_next  = {mask_key[23:0], data_byte};
            key_index_next = key_index + 2'd1;
            if (key_index_next == 2'd0) begin
              body_start = 1'b1;
            end
          end
          PH_BODY: begin
            key_index_next  = key_index + 2'd1;
            bytes_left_next = bytes_left - LEN_ONE;
            priority if (bad_reason != BAD_NONE) begin
              frame_end = body_last;
            end else if (opcode_reg == OP_CLOSE) begin
              if (close_byte_count < 2'd2) begin
                close_code_acc_next   = {close_code_acc[7:0], body_byte};
                close_byte_count_next = close_byte_count + 2'd1;
              end
              frame_end = body_last;
            end else begin
              if (body_last) begin
                phase_next = PH_HEAD;
              end
              res_valid   = 1'b1;
              res.kind    = KIND_PAYLOAD;
              res.data    = body_byte;
              res.opcode  = opcode_reg;
              res.fin     = fin_flag;
              res.last    = body_last;
            end
          end
          default: begin
            phase_next = PH_HALT;
          end
        endcase

        // Header complete: go to key bytes or straight to the body
        if (length_known) begin
          if (mask_present_next) begin
            key_index_next = '0;
            mask_key_next  = '0;
            phase_next     = PH_KEY;
          end else begin
            body_start = 1'b1;
          end
        end

        // Body begins; a zero length ends the frame at once
        if (body_start) begin
          key_index_next = '0;
          if (bytes_left_next == LEN_ZERO) begin
            frame_end = 1'b1;
          end else begin
            phase_next = PH_BODY;
          end
        end

        // End of frame with no payload beat to carry it
        if (frame_end) begin
          res_valid  = 1'b1;
          res.opcode = opcode_reg_next;
          res.fin    = fin_flag_next;
          res.last   = 1'b1;
          priority if (bad_reason_next != BAD_NONE) begin
            phase_next = PH_HALT;
            res.kind   = KIND_EVENT;
            res.reason = (bad_reason_next == BAD_UNMASKED) ? RSN_UNMASKED : RSN_BAD_OP;
          end else if (opcode_reg_next == OP_CLOSE) begin
            phase_next = PH_HALT;
            res.kind   = KIND_EVENT;
            res.reason = RSN_CLOSE;
            res.code   = (close_byte_count_next >= 2'd2) ? close_code_acc_next : 16'd0;
          end else begin
            phase_next = PH_HEAD;
            res.kind   = KIND_EMPTY;
          end
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEAD;
      server_mode      <= 1'b1;
      fin_flag         <= 1'b0;
      opcode_reg       <= OP_CONT;
      mask_present     <= 1'b0;
      bytes_left       <= LEN_ZERO;
      ext_len_count    <= '0;
      mask_key         <= '0;
      key_index        <= '0;
      close_code_acc   <= '0;
      close_byte_count <= '0;
      bad_reason       <= BAD_NONE;
    end else begin
      if (cfg_write_en) begin
        server_mode <= cfg_write_data;
      end
      if (accept) begin
        phase            <= phase_next;
        fin_flag         <= fin_flag_next;
        opcode_reg       <= opcode_reg_next;
        mask_present     <= mask_present_next;
        bytes_left       <= bytes_left_next;
        ext_len_count    <= ext_len_count_next;
        mask_key         <= mask_key_next;
        key_index        <= key_index_next;
        close_code_acc   <= close_code_acc_next;
        close_byte_count <= close_byte_count_next;
        bad_reason       <= bad_reason_next;
      end
    end
  end

endmodule

[rtl/wsd_out_reg.sv]
// Result register that holds one beat until the downstream side takes it.
module wsd_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  wsd_pkg::wsd_result_t load_data,
  output logic                 full,
  input  logic                 take_stall,
  output wsd_pkg::wsd_result_t data
);
  import wsd_pkg::*;

  // Valid flag: set on load, cleared when the beat leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (!take_stall) begin
      full <= 1'b0;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

[test/websocket_frame_deframer_core_tb.sv]
// Self-checking testbench for the WebSocket frame deframer core.
module websocket_frame_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wsd_pkg::*;

  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_BEATS = 25;

  typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;
  typedef enum int {END_CLOSE, END_BAD_OP, END_UNMASKED, END_STREAM} end_kind_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic        cfg_write_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        stream_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  result_kind;
  logic [7:0]  payload_byte;
  logic [3:0]  frame_opcode;
  logic        final_fragment;
  logic        last_of_frame;
  logic [2:0]  close_reason;
  logic [15:0] peer_close_code;

  // predictor state
  wsd_phase_t  cur_phase = PH_HEAD;
  logic        cur_fin = 1'b0;
  logic [3:0]  cur_op = 4'h0;
  logic        cur_masked = 1'b0;
  logic [63:0] bytes_to_go = '0;
  logic [3:0]  ext_to_go = '0;
  logic [31:0] cur_key = '0;
  logic [1:0]  key_pos = '0;
  logic [15:0] close_code = '0;
  logic [1:0]  close_count = '0;
  logic [1:0]  bad_reason = BAD_NONE;
  logic        server_side = 1'b1;

  wsd_result_t pending_results[$];
  logic [7:0]  frame_bytes[$];
  logic [3:0]  data_ops[4] = '{OP_TEXT, OP_BIN, OP_PING, OP_PONG};

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          mismatch_count = 0;
  int          results_seen = 0;
  int          beats_sent = 0;
  int          quiet_cycles = 0;
  wsd_result_t got_result;
  wsd_result_t want_result;

  websocket_frame_deframer_core i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .stream_end      (stream_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result_kind     (result_kind),
    .payload_byte    (payload_byte),
    .frame_opcode    (frame_opcode),
    .final_fragment  (final_fragment),
    .last_of_frame   (last_of_frame),
    .close_reason    (close_reason),
    .peer_close_code (peer_close_code)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Deframing predictor
  // ---------------------------------------------------------------
  function automatic bit op_supported(input logic [3:0] o);
    return o inside {OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG};
  endfunction

  // frame over with no payload beat to carry the end mark
  function automatic bit frame_wrap(output wsd_result_t r);
    r = '0;
    r.opcode = cur_op;
    r.fin = cur_fin;
    r.last = 1'b1;
    if (bad_reason != BAD_NONE) begin
      cur_phase = PH_HALT;
      r.kind = KIND_EVENT;
      r.reason = (bad_reason == BAD_OP) ? RSN_BAD_OP : RSN_UNMASKED;
    end else if (cur_op == OP_CLOSE) begin
      cur_phase = PH_HALT;
      r.kind = KIND_EVENT;
      r.reason = RSN_CLOSE;
      r.code = (close_count >= 2) ? close_code : 16'h0000;
    end else begin
      cur_phase = PH_HEAD;
      r.kind = KIND_EMPTY;
    end
    return 1'b1;
  endfunction

  function automatic bit enter_body(output wsd_result_t r);
    r = '0;
    key_pos = '0;
    if (bytes_to_go == 0) return frame_wrap(r);
    cur_phase = PH_BODY;
    return 1'b0;
  endfunction

  function automatic bit length_ready(output wsd_result_t r);
    r = '0;
    if (cur_masked) begin
      key_pos = '0;
      cur_key = '0;
      cur_phase = PH_KEY;
      return 1'b0;
    end
    return enter_body(r);
  endfunction

  // advance the parser by one accepted beat, queue any result it gives
  function automatic void deframe_byte(input logic [7:0] b, input logic e);
    wsd_result_t r;
    bit          hit;
    logic [7:0]  v;
    bit          at_end;
    r = '0;
    hit = 1'b0;
    if (cur_phase == PH_HALT) return;
    if (e) begin
      cur_phase = PH_HALT;
      r.kind = KIND_EVENT;
      r.last = 1'b1;
      r.reason = RSN_STREAM;
      hit = 1'b1;
    end else begin
      case (cur_phase)
        PH_HEAD: begin
          cur_fin = b[7];
          cur_op = b[3:0];
          close_code = '0;
          close_count = '0;
          cur_phase = PH_LEN;
        end
        PH_LEN: begin
          cur_masked = b[7];
          if (server_side && !cur_masked) bad_reason = BAD_UNMASKED;
          else if (op_supported(cur_op)) bad_reason = BAD_NONE;
          else bad_reason = BAD_OP;
          bytes_to_go = '0;
          if (b[6:0] < LEN_CODE_16) begin
            bytes_to_go = 64'(b[6:0]);
            hit = length_ready(r);
          end else begin
            ext_to_go = (b[6:0] == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
            cur_phase = PH_EXT;
          end
        end
        PH_EXT: begin
          bytes_to_go = {bytes_to_go[55:0], b};
          ext_to_go--;
          if (ext_to_go == 0) hit = length_ready(r);
        end
        PH_KEY: begin
          cur_key = {cur_key[23:0], b};
          key_pos++;
          if (key_pos == 0) hit = enter_body(r);
        end
        PH_BODY: begin
          v = b;
          if (cur_masked) v ^= cur_key[8 * (3 - key_pos) +: 8];
          key_pos++;
          bytes_to_go--;
          at_end = (bytes_to_go == 0);
          if (bad_reason != BAD_NONE) begin
            if (at_end) hit = frame_wrap(r);
          end else if (cur_op == OP_CLOSE) begin
            // only the leading two bytes make up the status code
            if (close_count < 2) begin
              close_code = {close_code[7:0], v};
              close_count++;
            end
            if (at_end) hit = frame_wrap(r);
          end else begin
            if (at_end) cur_phase = PH_HEAD;
            r.kind = KIND_PAYLOAD;
            r.data = v;
            r.opcode = cur_op;
            r.fin = cur_fin;
            r.last = at_end;
            hit = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (hit) pending_results.push_back(r);
  endfunction

  // ---------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------
  task automatic log_mismatch(input string what, input wsd_result_t w, input wsd_result_t g);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("result %0d %s: want kind=%0d data=%02h op=%0h fin=%0b last=%0b rsn=%0d code=%04h",
               results_seen, what, w.kind, w.data, w.opcode, w.fin, w.last, w.reason, w.code,
               "\n    got kind=%0d data=%02h op=%0h fin=%0b last=%0b rsn=%0d code=%04h",
               g.kind, g.data, g.opcode, g.fin, g.last, g.reason, g.code);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_result = {result_kind, payload_byte, frame_opcode, final_fragment, last_of_frame,
                    close_reason, peer_close_code};
      if (pending_results.size() == 0) begin
        log_mismatch("unexpected", '0, got_result);
      end else begin
        want_result = pending_results.pop_front();
        if (got_result !== want_result) log_mismatch("mismatch", want_result, got_result);
      end
      results_seen++;
    end
  end

  // output side stall, with an occasional long hold-off
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------
  task automatic send_beat(input logic [7:0] b, input logic e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    stream_end <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_byte(b, e);
    beats_sent++;
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // register writes happen only with the parser idle
  task automatic change_mode(input logic m);
    wait_results();
    repeat (4) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= m;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    server_side = m;
  endtask

  function automatic void build_frame(input logic [3:0] opc, input logic fin_b,
                                      input logic use_mask, input len_form_t form,
                                      input int unsigned len, input logic [31:0] mkey);
    logic [63:0] l64;
    logic [2:0]  rsv;
    l64 = 64'(len);
    rsv = 3'($urandom);
    frame_bytes.delete();
    frame_bytes.push_back({fin_b, rsv, opc});
    case (form)
      LEN_SHORT: frame_bytes.push_back({use_mask, l64[6:0]});
      LEN_EXT16: begin
        frame_bytes.push_back({use_mask, LEN_CODE_16});
        frame_bytes.push_back(l64[15:8]);
        frame_bytes.push_back(l64[7:0]);
      end
      default: begin
        frame_bytes.push_back({use_mask, LEN_CODE_64});
        for (int i = 7; i >= 0; i--) frame_bytes.push_back(l64[8 * i +: 8]);
      end
    endcase
    if (use_mask)
      for (int i = 3; i >= 0; i--) frame_bytes.push_back(mkey[8 * i +: 8]);
    repeat (len) frame_bytes.push_back(8'($urandom));
  endfunction

  task automatic drive_frame(input logic [3:0] opc, input logic fin_b, input logic use_mask,
                             input len_form_t form, input int unsigned len,
                             input logic [31:0] mkey, input bit pause_mid);
    build_frame(opc, fin_b, use_mask, form, len, mkey);
    for (int i = 0; i < frame_bytes.size(); i++) begin
      // sender stops mid-frame until every result so far is out
      if (pause_mid && i == frame_bytes.size() / 2) wait_results();
      send_beat(frame_bytes[i], 1'b0);
    end
  endtask

  task automatic random_frame();
    len_form_t   form;
    int unsigned len;
    int unsigned sel;
    logic [31:0] mkey;
    form = LEN_SHORT;
    sel = $urandom_range(99);
    if (sel < 10) len = 0;
    else if (sel < 75) len = $urandom_range(12, 1);
    else if (sel < 85) len = $urandom_range(125, 13);
    else if (sel < 93) begin
      form = LEN_EXT16;
      len = $urandom_range(200);
    end else begin
      form = LEN_EXT64;
      len = $urandom_range(200);
    end
    mkey = ($urandom_range(9) == 0) ? 32'h0 : $urandom;
    drive_frame(data_ops[$urandom_range(3)], 1'($urandom_range(1)),
                server_side | 1'($urandom_range(1)), form, len, mkey,
                $urandom_range(29) == 0);
  endtask

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------
  task automatic test_directed_frames();
    drive_frame(OP_TEXT, 1'b1, 1'b1, LEN_SHORT, 0, $urandom, 1'b0);
    drive_frame(OP_BIN, 1'b0, 1'b1, LEN_SHORT, 1, 32'hffff_ffff, 1'b0);
    drive_frame(OP_PING, 1'b1, 1'b1, LEN_SHORT, 125, $urandom, 1'b0);
    drive_frame(OP_PONG, 1'b1, 1'b1, LEN_SHORT, 5, 32'h0, 1'b0);
    drive_frame(OP_TEXT, 1'b0, 1'b1, LEN_EXT16, 0, $urandom, 1'b0);
    drive_frame(OP_BIN, 1'b1, 1'b1, LEN_EXT64, 0, $urandom, 1'b0);
    drive_frame(OP_PING, 1'b1, 1'b1, LEN_EXT16, 126, $urandom, 1'b0);
    drive_frame(OP_TEXT, 1'b1, 1'b1, LEN_EXT16, 40, $urandom, 1'b1);
    drive_frame(OP_PONG, 1'b0, 1'b1, LEN_EXT64, 258, $urandom, 1'b0);
  endtask

  // client side: unmasked frames are legal
  task automatic test_client_mode();
    change_mode(1'b0);
    drive_frame(OP_TEXT, 1'b1, 1'b0, LEN_SHORT, 3, 32'h0, 1'b0);
    drive_frame(OP_PING, 1'b1, 1'b0, LEN_SHORT, 0, 32'h0, 1'b0);
    drive_frame(OP_BIN, 1'b0, 1'b1, LEN_SHORT, 4, $urandom, 1'b0);
    drive_frame(OP_PONG, 1'b1, 1'b0, LEN_EXT16, 2, 32'h0, 1'b0);
    drive_frame(OP_TEXT, 1'b1, 1'b0, LEN_EXT64, 9, 32'h0, 1'b0);
    change_mode(1'b1);
  endtask

  // 16-bit length with the high byte in use
  task automatic test_long_length();
    drive_frame(OP_BIN, 1'b1, 1'b1, LEN_EXT16, 256, $urandom, 1'b0);
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    drive_frame(OP_TEXT, 1'b1, 1'b1, LEN_SHORT, 100, $urandom, 1'b0);
    wait_results();
  endtask

  task automatic test_random_traffic();
    int unsigned idle_set[4] = '{0, 52, 0, 18};
    int unsigned stall_set[4] = '{0, 0, 52, 18};
    int          stop_at;
    for (int p = 0; p < 4; p++) begin
      change_mode(p[0]);
      send_idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      stop_at = beats_sent + PHASE_BEATS;
      while (beats_sent < stop_at) random_frame();
    end
  endtask

  // one terminating event per run, then the block must stay silent
  task automatic test_terminal_event();
    end_kind_t   pick;
    logic [3:0]  opc;
    int unsigned len;
    int unsigned cut;
    pick = end_kind_t'($urandom_range(3));
    len = $urandom_range(10);
    case (pick)
      END_CLOSE: begin
        change_mode(1'($urandom_range(1)));
        len = $urandom_range(1) ? $urandom_range(2) : $urandom_range(20, 3);
        drive_frame(OP_CLOSE, 1'($urandom_range(1)), server_side | 1'($urandom_range(1)),
                    len_form_t'($urandom_range(2)), len, $urandom, 1'b0);
      end
      END_BAD_OP: begin
        change_mode(1'($urandom_range(1)));
        do opc = 4'($urandom); while (op_supported(opc));
        drive_frame(opc, 1'($urandom_range(1)), server_side | 1'($urandom_range(1)),
                    len_form_t'($urandom_range(2)), len, $urandom, 1'b0);
      end
      END_UNMASKED: begin
        change_mode(1'b1);
        drive_frame(4'($urandom), 1'($urandom_range(1)), 1'b0,
                    len_form_t'($urandom_range(2)), len, 32'h0, 1'b0);
      end
      default: begin
        build_frame(4'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    len_form_t'($urandom_range(2)), len, $urandom);
        cut = $urandom_range(frame_bytes.size());
        for (int i = 0; i < cut; i++) send_beat(frame_bytes[i], 1'b0);
        send_beat(8'($urandom), 1'b1);
      end
    endcase
    send_beat(8'($urandom), 1'b1);
    repeat (19) send_beat(8'($urandom), 1'($urandom_range(1)));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_frames();
    test_client_mode();
    test_long_length();
    test_backpressure();
    test_random_traffic();
    test_terminal_event();
    wait_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
